// ----- rtl/core/tcra_pkg.sv -----
// ----------------------------------------------------------------------------
// tcra_pkg
// Shared types and constants for the two-class request admission core:
// command codes, configuration indexes, queue sizing and the beat structs.
// ----------------------------------------------------------------------------
package tcra_pkg;

    // Queue sizing (each class has its own tag FIFO)
    localparam int Q_DEPTH = 1024;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = Q_AW + 1;
    localparam int QT_W    = 12;
    localparam int TAG_W   = 16;
    localparam int RUN_W   = 8;
    localparam int LVL_W   = 12;
    // combined occupancy of both queues, never narrower than a level
    localparam int QS_W    = (Q_CW + 1 > LVL_W) ? Q_CW + 1 : LVL_W;

    // Command codes
    localparam logic [1:0] CMD_SUBMIT_NORMAL = 2'd0;
    localparam logic [1:0] CMD_SUBMIT_SLOW   = 2'd1;
    localparam logic [1:0] CMD_COMPLETE      = 2'd2;
    localparam logic [1:0] CMD_READY         = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_RUNNING   = 2'd0;
    localparam logic [1:0] CFG_OVL_SET_LEVEL = 2'd1;
    localparam logic [1:0] CFG_OVL_CLR_LEVEL = 2'd2;

    // Configuration reset values
    localparam logic [RUN_W-1:0] RST_MAX_RUNNING = RUN_W'(8);
    localparam logic [LVL_W-1:0] RST_OVL_SET     = LVL_W'(1800);
    localparam logic [LVL_W-1:0] RST_OVL_CLR     = LVL_W'(1600);

    typedef struct packed {
        logic [1:0]       cmd;
        logic [TAG_W-1:0] request_tag;
    } t_in_item;

    typedef struct packed {
        logic             start_valid;
        logic [TAG_W-1:0] start_tag;
        logic             overload;
        logic             dropped;
        logic [RUN_W-1:0] running_now;
        logic [QT_W-1:0]  queued_now;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic exec;
        logic load_out;
    } t_ctl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_ctl_sts;

endpackage

// ----- rtl/core/tcra_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcra_ctrl
// Sequencer for one item: accept, execute (counter update and queue access),
// then load the result into the output register.
// ----------------------------------------------------------------------------
module tcra_ctrl
    import tcra_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_ctl_sts i_sts,
    output t_ctl_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd.capture  = 1'b0;
        o_cmd.exec     = 1'b0;
        o_cmd.load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_FIN;
            end
            S_FIN: begin
                // wait for room in the output register
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef NO_ASSERTIONS
    // an accepted beat is always followed by an execute step
    a_cap_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_cmd.exec)
        else $error("capture not followed by execute");

    // execute always leads to the result step
    a_exec_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> (r_state == S_FIN))
        else $error("execute not followed by result step");

    // the result is loaded only when the output register has room
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_sts.out_free)
        else $error("result loaded into a busy output register");
`endif

endmodule

// ----- rtl/core/tcra_dp.sv -----
// ----------------------------------------------------------------------------
// tcra_dp
// Datapath: configuration registers, running count, ready and overload flags,
// two tag FIFOs held in memories, and the output register.
// ----------------------------------------------------------------------------
module tcra_dp
    import tcra_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_in_item         i_in_data,
    input  logic             i_cfg_valid,
    input  logic [1:0]       i_cfg_index,
    input  logic [LVL_W-1:0] i_cfg_data,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output t_out_item        o_out_data,
    input  t_ctl_cmd         i_cmd,
    output t_ctl_sts         o_sts
);

    // Configuration
    logic [RUN_W-1:0] r_max_run;
    logic [LVL_W-1:0] r_set_lvl;
    logic [LVL_W-1:0] r_clr_lvl;

    // Captured item
    logic [1:0]       r_cmd;
    logic [TAG_W-1:0] r_tag;

    // Block state
    logic             r_ready, n_ready;
    logic             r_ovl, n_ovl;
    logic [RUN_W-1:0] r_run, n_run;
    logic [Q_AW-1:0]  r_nhead, n_nhead;
    logic [Q_CW-1:0]  r_ncnt, n_ncnt;
    logic [Q_AW-1:0]  r_shead, n_shead;
    logic [Q_CW-1:0]  r_scnt, n_scnt;

    // Per-item result flags
    logic             r_started, n_started;
    logic             r_from_q, n_from_q;
    logic             r_from_slow, n_from_slow;
    logic             r_dropped, n_dropped;

    // Output register
    logic             r_out_valid;
    t_out_item        r_out;

    // Queue memories
    logic [TAG_W-1:0] r_nmem [Q_DEPTH];
    logic [TAG_W-1:0] r_smem [Q_DEPTH];
    logic [TAG_W-1:0] r_nrd;
    logic [TAG_W-1:0] r_srd;

    logic             wr_n, wr_s, rd_n, rd_s;
    logic [Q_AW-1:0]  wr_addr;
    logic [QS_W-1:0]  total;
    logic             can_now;
    logic [RUN_W-1:0] run_dec;
    logic             rdy_q;
    logic             can_q;
    logic             is_submit;
    logic             full_sel;
    t_out_item        res;

    // full combined count; the levels compare against all of it
    assign total     = QS_W'(r_ncnt) + QS_W'(r_scnt);
    assign can_now   = r_ready && (r_run < r_max_run);
    assign is_submit = (r_cmd == CMD_SUBMIT_NORMAL) || (r_cmd == CMD_SUBMIT_SLOW);
    assign full_sel  = (r_cmd == CMD_SUBMIT_NORMAL) ? (r_ncnt == Q_CW'(Q_DEPTH))
                                                    : (r_scnt == Q_CW'(Q_DEPTH));
    assign run_dec   = (r_cmd == CMD_COMPLETE && r_run != '0) ? r_run - 1'b1 : r_run;
    assign rdy_q     = r_ready || (r_cmd == CMD_READY);
    assign can_q     = rdy_q && (run_dec < r_max_run);

    // Execute step: admission decision, queue push or pop
    always_comb begin
        n_ready     = r_ready;
        n_ovl       = r_ovl;
        n_run       = r_run;
        n_nhead     = r_nhead;
        n_ncnt      = r_ncnt;
        n_shead     = r_shead;
        n_scnt      = r_scnt;
        n_started   = r_started;
        n_from_q    = r_from_q;
        n_from_slow = r_from_slow;
        n_dropped   = r_dropped;
        wr_n        = 1'b0;
        wr_s        = 1'b0;
        rd_n        = 1'b0;
        rd_s        = 1'b0;
        wr_addr     = (r_cmd == CMD_SUBMIT_NORMAL) ? r_nhead + r_ncnt[Q_AW-1:0]
                                                   : r_shead + r_scnt[Q_AW-1:0];
        if (i_cmd.exec) begin
            n_started   = 1'b0;
            n_from_q    = 1'b0;
            n_from_slow = 1'b0;
            n_dropped   = 1'b0;
            if (is_submit) begin
                if (can_now) begin
                    n_run     = r_run + 1'b1;
                    n_started = 1'b1;
                end else begin
                    // overload check uses the count before the push
                    if (!r_ovl && total > QS_W'(r_set_lvl)) begin
                        n_ovl = 1'b1;
                    end
                    if (full_sel) begin
                        n_dropped = 1'b1;
                    end else if (r_cmd == CMD_SUBMIT_NORMAL) begin
                        wr_n   = 1'b1;
                        n_ncnt = r_ncnt + 1'b1;
                    end else begin
                        wr_s   = 1'b1;
                        n_scnt = r_scnt + 1'b1;
                    end
                end
            end else begin
                n_run = run_dec;
                if (r_cmd == CMD_COMPLETE) begin
                    if (r_ovl && total < QS_W'(r_clr_lvl)) begin
                        n_ovl = 1'b0;
                    end
                end else begin
                    n_ready = 1'b1;
                end
                // start one queued tag, normal class first
                if (can_q && r_ncnt != '0) begin
                    rd_n      = 1'b1;
                    n_nhead   = r_nhead + 1'b1;
                    n_ncnt    = r_ncnt - 1'b1;
                    n_run     = run_dec + 1'b1;
                    n_started = 1'b1;
                    n_from_q  = 1'b1;
                end else if (can_q && r_scnt != '0) begin
                    rd_s        = 1'b1;
                    n_shead     = r_shead + 1'b1;
                    n_scnt      = r_scnt - 1'b1;
                    n_run       = run_dec + 1'b1;
                    n_started   = 1'b1;
                    n_from_q    = 1'b1;
                    n_from_slow = 1'b1;
                end
            end
        end
    end

    // Result beat assembled from state after the item
    always_comb begin
        res.start_valid = r_started;
        if (!r_started) begin
            res.start_tag = '0;
        end else if (!r_from_q) begin
            res.start_tag = r_tag;
        end else if (r_from_slow) begin
            res.start_tag = r_srd;
        end else begin
            res.start_tag = r_nrd;
        end
        res.overload    = r_ovl;
        res.dropped     = r_dropped;
        res.running_now = r_run;
        res.queued_now  = total[QT_W-1:0];
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_run   <= RST_MAX_RUNNING;
            r_set_lvl   <= RST_OVL_SET;
            r_clr_lvl   <= RST_OVL_CLR;
            r_ready     <= 1'b0;
            r_ovl       <= 1'b0;
            r_run       <= '0;
            r_nhead     <= '0;
            r_ncnt      <= '0;
            r_shead     <= '0;
            r_scnt      <= '0;
            r_started   <= 1'b0;
            r_from_q    <= 1'b0;
            r_from_slow <= 1'b0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MAX_RUNNING:   r_max_run <= i_cfg_data[RUN_W-1:0];
                    CFG_OVL_SET_LEVEL: r_set_lvl <= i_cfg_data;
                    CFG_OVL_CLR_LEVEL: r_clr_lvl <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_ready     <= n_ready;
            r_ovl       <= n_ovl;
            r_run       <= n_run;
            r_nhead     <= n_nhead;
            r_ncnt      <= n_ncnt;
            r_shead     <= n_shead;
            r_scnt      <= n_scnt;
            r_started   <= n_started;
            r_from_q    <= n_from_q;
            r_from_slow <= n_from_slow;
            r_dropped   <= n_dropped;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd <= i_in_data.cmd;
            r_tag <= i_in_data.request_tag;
        end
        if (i_cmd.load_out) begin
            r_out <= res;
        end
    end

    // Normal class queue memory
    always_ff @(posedge i_clk) begin
        if (wr_n) begin
            r_nmem[wr_addr] <= r_tag;
        end
        if (rd_n) begin
            r_nrd <= r_nmem[r_nhead];
        end
    end

    // Slow class queue memory
    always_ff @(posedge i_clk) begin
        if (wr_s) begin
            r_smem[wr_addr] <= r_tag;
        end
        if (rd_s) begin
            r_srd <= r_smem[r_shead];
        end
    end

`ifndef NO_ASSERTIONS
    a_ncnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ncnt <= Q_CW'(Q_DEPTH))
        else $error("normal queue count above depth");

    a_scnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scnt <= Q_CW'(Q_DEPTH))
        else $error("slow queue count above depth");

    // a started request is counted as running
    a_start_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.start_valid) |-> (r_out.running_now != '0))
        else $error("start reported with nothing running");

    // a dropped submit never starts anything
    a_drop_nostart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.dropped) |-> !r_out.start_valid)
        else $error("dropped submit also reported a start");

    // a pop only happens when the block may start a request
    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_n || rd_s) |-> (can_q && !is_submit))
        else $error("queue popped without a free running slot");
`endif

endmodule

// ----- rtl/core/two_class_request_admission_core.sv -----
// ----------------------------------------------------------------------------
// two_class_request_admission_core
// Admission control for outstanding requests with a normal and a slow class.
// ----------------------------------------------------------------------------
// Each accepted beat gives exactly one result beat. An item passes from
// acceptance to the result register through accept, execute and load steps,
// set by the registered read port of the tag FIFO memories; load waits for
// room in the output register. The next item is accepted in the cycle after
// the result is loaded, even while that result still waits downstream, so a
// new item is never taken before the last one is loaded. Both tag FIFOs are
// 1024-entry memories with no clearing pass: only occupied entries are ever
// read. The configuration port is always ready; write it only while the
// block is idle. Writes to an index beyond the register list are ignored.
module two_class_request_admission_core
    import tcra_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // item input
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    // result output
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data,
    // configuration writes
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [LVL_W-1:0] i_cfg_data
);

    t_ctl_cmd ctl_cmd;
    t_ctl_sts ctl_sts;

    assign o_cfg_ready = 1'b1;

    // Item sequencer
    tcra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (ctl_sts),
        .o_cmd      (ctl_cmd)
    );

    // Counters, queues and result register
    tcra_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (ctl_cmd),
        .o_sts       (ctl_sts)
    );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the two-class request admission core. A short
// table of directed beats runs on the reset settings, then several phases of
// random beats, each under its own register settings and idling pattern. A
// built-in admission model predicts the result beats the table leaves free;
// the result channel is compared field by field against them, oldest first.
// ----------------------------------------------------------------------------
module tb_top;
    import tcra_pkg::*;

    localparam int         CLK_HALF      = 5;
    localparam int         RST_CYCLES    = 10;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         SETTLE_CYCLES = 10;
    localparam int         MAX_REPORTS   = 10;
    // index past the register list, writes to it must be ignored
    localparam logic [1:0] CFG_SPARE_IDX = 2'd3;

    typedef struct {
        t_in_item  beat;
        bit        fixed;
        t_out_item result;
    } t_dir_row;

    typedef struct {
        logic [RUN_W-1:0] max_run;
        logic [LVL_W-1:0] set_lvl;
        logic [LVL_W-1:0] clr_lvl;
        int               n_items;
        int               idle_pct;
        int               stall_pct;
        int               w_norm;
        int               w_slow;
        int               w_comp;
    } t_phase;

    // DUT connections
    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    t_in_item         in_data   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_out_item        out_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [1:0]       cfg_index = '0;
    logic [LVL_W-1:0] cfg_data  = '0;

    // Admission model state and its copy of the registers
    logic             adm_ready    = 1'b0;
    logic             adm_overload = 1'b0;
    logic [RUN_W-1:0] adm_running  = '0;
    logic [TAG_W-1:0] normal_tags[$];
    logic [TAG_W-1:0] slow_tags[$];
    logic [RUN_W-1:0] lim_running  = RST_MAX_RUNNING;
    logic [LVL_W-1:0] lim_set      = RST_OVL_SET;
    logic [LVL_W-1:0] lim_clr      = RST_OVL_CLR;

    t_out_item        pending_results[$];

    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int cycle_cnt     = 0;
    int err_cnt       = 0;
    int beats_sent    = 0;
    int results_seen  = 0;
    int drops_seen    = 0;
    int overload_seen = 0;

    two_class_request_admission_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------------
    // Admission model
    // ------------------------------------------------------------------------
    function automatic bit slot_free();
        return adm_ready && (adm_running < lim_running);
    endfunction

    // Start the oldest queued tag, normal class served first
    function automatic void start_queued(inout t_out_item r);
        if (!slot_free())
            return;
        if (normal_tags.size() != 0)
            r.start_tag = normal_tags.pop_front();
        else if (slow_tags.size() != 0)
            r.start_tag = slow_tags.pop_front();
        else
            return;
        r.start_valid = 1'b1;
        adm_running++;
    endfunction

    function automatic t_out_item predict_admission(input t_in_item beat);
        t_out_item r;
        int        qtot;
        r    = '0;
        qtot = normal_tags.size() + slow_tags.size();
        case (beat.cmd)
            CMD_SUBMIT_NORMAL, CMD_SUBMIT_SLOW: begin
                if (slot_free()) begin
                    adm_running++;
                    r.start_valid = 1'b1;
                    r.start_tag   = beat.request_tag;
                end else begin
                    // overload is judged on the count before the push
                    if (!adm_overload && qtot > lim_set)
                        adm_overload = 1'b1;
                    if (beat.cmd == CMD_SUBMIT_NORMAL) begin
                        if (normal_tags.size() < Q_DEPTH)
                            normal_tags.push_back(beat.request_tag);
                        else
                            r.dropped = 1'b1;
                    end else begin
                        if (slow_tags.size() < Q_DEPTH)
                            slow_tags.push_back(beat.request_tag);
                        else
                            r.dropped = 1'b1;
                    end
                end
            end
            CMD_COMPLETE: begin
                // running count saturates at zero
                if (adm_running != 0)
                    adm_running--;
                if (adm_overload && qtot < lim_clr)
                    adm_overload = 1'b0;
                start_queued(r);
            end
            default: begin
                adm_ready = 1'b1;
                start_queued(r);
            end
        endcase
        r.overload    = adm_overload;
        r.running_now = adm_running;
        r.queued_now  = QT_W'(normal_tags.size() + slow_tags.size());
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_dir_row fixed_row(input logic [1:0] cmd, input logic [TAG_W-1:0] tag,
                                           input logic sv, input logic [TAG_W-1:0] st,
                                           input logic ov, input logic dr,
                                           input logic [RUN_W-1:0] rn,
                                           input logic [QT_W-1:0] qn);
        t_dir_row row;
        row.beat.cmd           = cmd;
        row.beat.request_tag   = tag;
        row.fixed              = 1'b1;
        row.result.start_valid = sv;
        row.result.start_tag   = st;
        row.result.overload    = ov;
        row.result.dropped     = dr;
        row.result.running_now = rn;
        row.result.queued_now  = qn;
        return row;
    endfunction

    function automatic t_dir_row free_row(input logic [1:0] cmd, input logic [TAG_W-1:0] tag);
        t_dir_row row;
        row.beat.cmd         = cmd;
        row.beat.request_tag = tag;
        row.fixed            = 1'b0;
        row.result           = '0;
        return row;
    endfunction

    function automatic t_phase phase_cfg(input int max_run, input int set_lvl,
                                         input int clr_lvl, input int n_items,
                                         input int idle_pct, input int stall_pct,
                                         input int w_norm, input int w_slow,
                                         input int w_comp);
        t_phase p;
        p.max_run   = RUN_W'(max_run);
        p.set_lvl   = LVL_W'(set_lvl);
        p.clr_lvl   = LVL_W'(clr_lvl);
        p.n_items   = n_items;
        p.idle_pct  = idle_pct;
        p.stall_pct = stall_pct;
        p.w_norm    = w_norm;
        p.w_slow    = w_slow;
        p.w_comp    = w_comp;
        return p;
    endfunction

    // Present one beat, wait for acceptance, then queue its expected result
    task automatic send_beat(input t_in_item beat, input bit use_fixed,
                             input t_out_item fixed_res);
        t_out_item predicted;
        if ($urandom_range(0, 99) < in_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < in_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge clk); while (in_stall);
        predicted = predict_admission(beat);
        pending_results.push_back(use_fixed ? fixed_res : predicted);
        beats_sent++;
    endtask

    // Sender goes quiet until every expected result has arrived
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    // Write all registers plus the spare index, valid held high throughout
    task automatic write_config(input t_phase p);
        logic [1:0]       idx[4];
        logic [LVL_W-1:0] val[4];
        idx[0] = CFG_MAX_RUNNING;
        idx[1] = CFG_OVL_SET_LEVEL;
        idx[2] = CFG_OVL_CLR_LEVEL;
        idx[3] = CFG_SPARE_IDX;
        // upper data bits of max_running are junk and must be ignored
        val[0] = {(LVL_W - RUN_W)'($urandom), p.max_run};
        val[1] = p.set_lvl;
        val[2] = p.clr_lvl;
        val[3] = LVL_W'($urandom);
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge clk); while (!cfg_ready);
            case (idx[i])
                CFG_MAX_RUNNING:   lim_running = val[i][RUN_W-1:0];
                CFG_OVL_SET_LEVEL: lim_set     = val[i];
                CFG_OVL_CLR_LEVEL: lim_clr     = val[i];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_dir_row dir_tab[$];
        t_phase   plan[$];
        t_in_item beat;
        int       pick;

        // Directed beats on reset settings (max_running 8)
        // completion with nothing running, block not yet ready
        dir_tab.push_back(fixed_row(CMD_COMPLETE, 16'h0000, 0, 16'h0000, 0, 0, 0, 0));
        // submits before ready are all queued
        dir_tab.push_back(fixed_row(CMD_SUBMIT_NORMAL, 16'hFFFF, 0, 16'h0000, 0, 0, 0, 1));
        dir_tab.push_back(fixed_row(CMD_SUBMIT_SLOW, 16'h0000, 0, 16'h0000, 0, 0, 0, 2));
        dir_tab.push_back(fixed_row(CMD_SUBMIT_SLOW, 16'h8001, 0, 16'h0000, 0, 0, 0, 3));
        dir_tab.push_back(fixed_row(CMD_SUBMIT_NORMAL, 16'h1234, 0, 16'h0000, 0, 0, 0, 4));
        // ready starts the normal head, ready again starts the next one
        dir_tab.push_back(fixed_row(CMD_READY, 16'h5A5A, 1, 16'hFFFF, 0, 0, 1, 3));
        dir_tab.push_back(fixed_row(CMD_READY, 16'h0000, 1, 16'h1234, 0, 0, 2, 2));
        // normal empty: completion starts the slow head, whose tag is zero
        dir_tab.push_back(fixed_row(CMD_COMPLETE, 16'hFFFF, 1, 16'h0000, 0, 0, 2, 1));
        // immediate starts while below the limit
        dir_tab.push_back(fixed_row(CMD_SUBMIT_NORMAL, 16'hAAAA, 1, 16'hAAAA, 0, 0, 3, 1));
        dir_tab.push_back(fixed_row(CMD_SUBMIT_SLOW, 16'h5555, 1, 16'h5555, 0, 0, 4, 1));
        dir_tab.push_back(free_row(CMD_SUBMIT_NORMAL, 16'h0001));
        dir_tab.push_back(free_row(CMD_SUBMIT_SLOW, 16'h0002));
        dir_tab.push_back(free_row(CMD_SUBMIT_NORMAL, 16'h4000));
        dir_tab.push_back(free_row(CMD_SUBMIT_NORMAL, 16'h8000));
        // at the limit: submits queue, ready starts nothing
        dir_tab.push_back(free_row(CMD_SUBMIT_NORMAL, 16'h7FFF));
        dir_tab.push_back(free_row(CMD_SUBMIT_SLOW, 16'hFFFE));
        dir_tab.push_back(free_row(CMD_READY, 16'hBEEF));
        // completions hand slots to queued tags, normal first
        dir_tab.push_back(free_row(CMD_COMPLETE, 16'hFFFF));
        dir_tab.push_back(free_row(CMD_COMPLETE, 16'h0000));
        dir_tab.push_back(free_row(CMD_COMPLETE, 16'h1111));
        dir_tab.push_back(free_row(CMD_COMPLETE, 16'h2222));
        dir_tab.push_back(free_row(CMD_COMPLETE, 16'h0F0F));

        // Random phases: settings, beat count, idling, command mix
        // tightest limit, overload on any backlog, clears on every completion
        plan.push_back(phase_cfg(1, 0, 2048, 80, 0, 0, 30, 30, 25));
        // widest limit, flag never moves; sender mostly idle
        plan.push_back(phase_cfg(255, 2048, 0, 80, 81, 0, 35, 25, 25));
        // small random settings; receiver mostly stalling
        plan.push_back(phase_cfg($urandom_range(1, 6), $urandom_range(0, 6),
                                 $urandom_range(0, 8), 80, 0, 81, 30, 25, 35));
        plan.push_back(phase_cfg($urandom_range(1, 4), $urandom_range(0, 12),
                                 $urandom_range(0, 12), 80, 7, 7, 30, 30, 30));
        // nothing may start: fill the normal queue until it drops
        plan.push_back(phase_cfg(0, 1023, 1100, 1100, 0, 0, 95, 3, 2));
        // drain from a deep backlog
        plan.push_back(phase_cfg(255, 0, 2048, 100, 0, 0, 25, 15, 30));

        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_beat(dir_tab[i].beat, dir_tab[i].fixed, dir_tab[i].result);

        foreach (plan[p]) begin
            hold_until_drained();
            write_config(plan[p]);
            in_idle_pct   = plan[p].idle_pct;
            out_stall_pct = plan[p].stall_pct;
            for (int k = 0; k < plan[p].n_items; k++) begin
                if (k == plan[p].n_items / 2)
                    hold_until_drained();
                pick = $urandom_range(0, 99);
                if (pick < plan[p].w_norm)
                    beat.cmd = CMD_SUBMIT_NORMAL;
                else if (pick < plan[p].w_norm + plan[p].w_slow)
                    beat.cmd = CMD_SUBMIT_SLOW;
                else if (pick < plan[p].w_norm + plan[p].w_slow + plan[p].w_comp)
                    beat.cmd = CMD_COMPLETE;
                else
                    beat.cmd = CMD_READY;
                beat.request_tag = TAG_W'($urandom_range(0, 65535));
                send_beat(beat, 1'b0, '0);
            end
        end

        hold_until_drained();
        out_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d beats sent (%0d directed, %0d phases), %0d results checked",
                 beats_sent, dir_tab.size(), plan.size(), results_seen);
        $display("%0d full-queue drops, %0d results with overload set, %0d mismatches",
                 drops_seen, overload_seen, err_cnt);
        if (err_cnt == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver stall pattern
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("cycle %0d: result beat %h with nothing pending",
                             cycle_cnt, out_data);
            end else begin
                want = pending_results.pop_front();
                results_seen++;
                if (want.dropped)
                    drops_seen++;
                if (want.overload)
                    overload_seen++;
                if (out_data.start_valid !== want.start_valid ||
                    out_data.start_tag   !== want.start_tag   ||
                    out_data.overload    !== want.overload    ||
                    out_data.dropped     !== want.dropped     ||
                    out_data.running_now !== want.running_now ||
                    out_data.queued_now  !== want.queued_now) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS) begin
                        $display("cycle %0d: mismatch on result %0d", cycle_cnt, results_seen);
                        $display("  exp sv=%0b tag=%h ovl=%0b drop=%0b run=%0d q=%0d",
                                 want.start_valid, want.start_tag, want.overload,
                                 want.dropped, want.running_now, want.queued_now);
                        $display("  got sv=%0b tag=%h ovl=%0b drop=%0b run=%0d q=%0d",
                                 out_data.start_valid, out_data.start_tag, out_data.overload,
                                 out_data.dropped, out_data.running_now, out_data.queued_now);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("watchdog: %0d cycles, %0d results still pending",
                     cycle_cnt, pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
